@@ hw/rtl/exact_palette_color_indexer_assert.svh @@
// Assertion macros used by the palette indexer top level.
`ifndef EXACT_PALETTE_COLOR_INDEXER_ASSERT_SVH
`define EXACT_PALETTE_COLOR_INDEXER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checks a property at every clock edge outside reset.
`define EPCI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checks that a condition is followed by another in the next cycle.
`define EPCI_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define EPCI_ASSERT(lbl, prop, msg)
`define EPCI_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ hw/rtl/epci_pkg.sv @@
// Shared types and constants of the palette color indexer.
`timescale 1ns / 1ps
`default_nettype none
package epci_pkg;

  localparam int COLOR_W     = 24;
  localparam int CHAN_W      = 8;
  localparam int INDEX_W     = 8;
  localparam int COUNT_W     = 9;
  localparam int INDEX_LIMIT = 256;

  // One pixel word on the input channel.
  typedef struct packed {
    logic              first_of_image;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  // One result word on the output channel.
  typedef struct packed {
    logic [INDEX_W-1:0] color_index;
    logic               is_new_color;
    logic               full_miss;
    logic [COUNT_W-1:0] colors_held;
  } result_t;

  // Search status handed from one cell to the next.
  typedef struct packed {
    logic               active;
    logic               found;
    logic               added;
    logic [INDEX_W-1:0] index;
  } link_t;

endpackage
`default_nettype wire

@@ hw/rtl/epci_pixel_if.sv @@
// Valid/ready channel that carries pixel words.
`timescale 1ns / 1ps
`default_nettype none
interface epci_pixel_if;
  import epci_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/epci_result_if.sv @@
// Valid/ready channel that carries palette result words.
`timescale 1ns / 1ps
`default_nettype none
interface epci_result_if;
  import epci_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/epci_cell.sv @@
// One palette table entry with its compare and append logic.
`timescale 1ns / 1ps
`default_nettype none
module epci_cell #(
  parameter int CELL_INDEX = 0
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       enable,
  input  wire [epci_pkg::COLOR_W-1:0] color,
  input  wire [epci_pkg::COUNT_W-1:0] count,
  input  epci_pkg::link_t           link_in,
  output epci_pkg::link_t           link_out
);
  import epci_pkg::*;

  localparam logic [COUNT_W-1:0] MY_POS   = COUNT_W'(CELL_INDEX);
  localparam logic [INDEX_W-1:0] MY_INDEX = INDEX_W'(CELL_INDEX);

  logic [COLOR_W-1:0] entry;
  logic               searching;
  logic               hit;
  logic               claim;
  link_t              link_next;

  // A live entry that matches ends the search; the first free slot takes a new color.
  assign searching = link_in.active && !link_in.found;
  assign hit       = searching && (MY_POS < count) && (entry == color);
  assign claim     = searching && (MY_POS == count);

  always_comb begin
    link_next        = link_in;
    link_next.found  = link_in.found | hit | claim;
    link_next.added  = link_in.added | claim;
    if (hit || claim) begin
      link_next.index = MY_INDEX;
    end
  end

  // The entry is written only when this cell appends the color.
  always_ff @(posedge clk) begin
    if (enable && claim) begin
      entry <= color;
    end
  end

  // Hand the search status to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.active <= 1'b0;
    end else if (enable) begin
      link_out.active <= link_next.active;
    end
    if (enable) begin
      link_out.found <= link_next.found;
      link_out.added <= link_next.added;
      link_out.index <= link_next.index;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/exact_palette_color_indexer.sv @@
// Top level of the exact palette color indexer.
// The indexer turns each RGB pixel word into a palette index, keeping up to
// min(TABLE_DEPTH, 256) distinct colors in order of first appearance. Each table
// entry lives in a cell of a chain; a search word enters the first cell and moves
// one cell per cycle, passing every cell register before its result is loaded
// into the output register, and the next pixel is taken only once that result
// is loaded, so a single pixel is in flight at a time. The walk down the cell
// chain sets the pixel rate. The result sits in an output register, so a stalled
// result only holds the chain once the next search word reaches its end. A
// first_of_image word empties the table before its own pixel is looked up.
`timescale 1ns / 1ps
`default_nettype none
module exact_palette_color_indexer #(
  parameter int TABLE_DEPTH = 256
) (
  input wire            clk,
  input wire            rst,
  epci_pixel_if.sink    pixel,
  epci_result_if.source result
);
  import epci_pkg::*;
  `include "exact_palette_color_indexer_assert.svh"

  localparam int CAPACITY = (TABLE_DEPTH < INDEX_LIMIT) ? TABLE_DEPTH : INDEX_LIMIT;

  logic               busy;
  logic               launch;
  logic [COLOR_W-1:0] color;
  logic [COUNT_W-1:0] count;
  logic               out_valid;
  result_t            out_data;
  logic               accept;
  logic               load;
  logic               advance;
  link_t              links [CAPACITY+1];
  link_t              tail_link;

  assign accept    = pixel.valid && pixel.ready;
  assign tail_link = links[CAPACITY];

  // The chain holds still only while a finished search waits on a full output.
  assign advance = !(tail_link.active && out_valid && !result.ready);
  assign load    = tail_link.active && advance;

  assign pixel.ready  = !busy;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  // The first cell sees a fresh search word the cycle after acceptance.
  always_comb begin
    links[0]        = '0;
    links[0].active = launch;
  end

  // Row of table cells.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    epci_cell #(
      .CELL_INDEX(k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .enable   (advance),
      .color    (color),
      .count    (count),
      .link_in  (links[k]),
      .link_out (links[k+1])
    );
  end

  // Control: one pixel in flight, color count, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      launch    <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      launch <= accept;
      if (accept) begin
        busy <= 1'b1;
        if (pixel.data.first_of_image) begin
          count <= '0;
        end
      end else if (load) begin
        busy  <= 1'b0;
        count <= count + COUNT_W'(tail_link.added);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Pixel color held for the whole search, result word at the chain end.
  always_ff @(posedge clk) begin
    if (accept) begin
      color <= {pixel.data.red, pixel.data.green, pixel.data.blue};
    end
    if (load) begin
      out_data.color_index  <= tail_link.found ? tail_link.index : '0;
      out_data.is_new_color <= tail_link.added;
      out_data.full_miss    <= !tail_link.found;
      out_data.colors_held  <= count + COUNT_W'(tail_link.added);
    end
  end

  `EPCI_ASSERT(a_count_cap, count <= COUNT_W'(CAPACITY), "color count above capacity")
  `EPCI_ASSERT(a_tail_busy, tail_link.active |-> busy, "search word without a pixel in flight")
  `EPCI_ASSERT_NEXT(a_accept_busy, accept, !pixel.ready, "second pixel taken during a search")
  `EPCI_ASSERT(a_new_or_miss, out_valid |-> !(out_data.is_new_color && out_data.full_miss), "result both new and miss")
  `EPCI_ASSERT(a_count_hold, (!$past(accept) && !$past(load)) |-> $stable(count), "count changed outside a pixel")

endmodule
`default_nettype wire
